[design/sle_pkg.sv]
// Shared types and constants for the sequential list engine.
// Used by sle_cell and sequential_list_engine; depends on nothing else.
`default_nettype none

package sle_pkg;

  localparam int DATA_W     = 32;
  localparam int POS_W      = 7;
  localparam int ACT_W      = 2;
  localparam int CELL_IDX_W = 11;
  localparam int SCAN_W     = 8;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOCATE = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ACT_W-1:0]  action;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

[design/sle_cell.sv]
// One list cell: holds a single entry and shifts with its neighbours.
// Depends on sle_pkg for the command struct and the action codes.
`default_nettype none

module sle_cell #(
  parameter int IDX = 0
) (
  input  wire                         clk,
  input  sle_pkg::cmd_t               cmd,
  input  wire  [sle_pkg::DATA_W-1:0]  left_data,
  input  wire  [sle_pkg::DATA_W-1:0]  right_data,
  output logic [sle_pkg::DATA_W-1:0]  data,
  output logic [sle_pkg::DATA_W-1:0]  hit_data,
  output logic                        match
);
  import sle_pkg::*;

  logic [CELL_IDX_W-1:0] idx1;
  logic [CELL_IDX_W-1:0] pos_ext;
  logic                  at_pos;

  assign idx1     = CELL_IDX_W'(IDX + 1);
  assign pos_ext  = CELL_IDX_W'(cmd.position);
  assign at_pos   = (idx1 == pos_ext);
  assign match    = (data == cmd.value);
  assign hit_data = data & {DATA_W{at_pos}};

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      case (cmd.action)
        ACT_INSERT: begin
          if (idx1 > pos_ext) begin
            data <= left_data;
          end else if (at_pos) begin
            data <= cmd.value;
          end
        end
        ACT_DELETE: begin
          if (idx1 >= pos_ext) begin
            data <= right_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/sequential_list_engine.sv]
// Top level of the sequential list engine: request handling, length count,
// locate scan and output register. Depends on sle_pkg and sle_cell.
//
// Usage: a request item (action, position, value) enters on the in_valid /
// in_ready channel; exactly one result item (ok, removed_value,
// found_position, list_length) leaves on the out_valid / out_ready channel.
// The list lives in a row of CAPACITY cells; insert and delete shift every
// cell beyond the position by one place, all cells together.
// Insert, delete and rejected requests pass through the EXEC and DONE states
// before their result is registered at the output. A locate compares all cells
// at once and then scans the match flags eight cells per cycle, so how long it
// takes depends on where the first match lies.
// One request is worked on at a time; a new one is accepted as soon as the
// previous result has been moved to the output register, even while that
// result is still waiting to be taken.
// Reset empties the list (length 0) and drops any pending result. When the
// receiver stalls, the result is held stable and the engine waits before
// writing the next one.
`default_nettype none

module sequential_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [sle_pkg::ACT_W-1:0]         action,
  input  wire  [sle_pkg::POS_W-1:0]         position,
  input  wire  signed [sle_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              ok,
  output logic signed [sle_pkg::DATA_W-1:0] removed_value,
  output logic [sle_pkg::POS_W-1:0]         found_position,
  output logic [sle_pkg::POS_W-1:0]         list_length
);
  import sle_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int NCHUNK = (CAPACITY + SCAN_W - 1) / SCAN_W;
  localparam int MV_W   = NCHUNK * SCAN_W;
  localparam int BASE_W = $clog2(MV_W + 1);
  localparam int ENC_W  = $clog2(SCAN_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state;
  logic [ACT_W-1:0]    req_action;
  logic [POS_W-1:0]    req_position;
  logic [DATA_W-1:0]   req_value;
  logic                req_ok;
  logic [CNT_W-1:0]    count;
  logic [MV_W-1:0]     match_vec;
  logic [BASE_W-1:0]   scan_base;
  logic [DATA_W-1:0]   res_removed;
  logic [POS_W-1:0]    res_found;

  cmd_t                cmd;
  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic [DATA_W-1:0]   cell_hit  [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] live;
  logic [DATA_W-1:0]   removed_or;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                ins_ok;
  logic                del_ok;
  logic [SCAN_W-1:0]   chunk;
  logic [ENC_W-1:0]    enc;
  logic                out_free;

  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(count);
  assign ins_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1)) &&
                    (cnt_ext < CMP_W'(CAPACITY));
  assign del_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign cmd = {(state == ST_EXEC) && req_ok, req_action, req_position, req_value};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = req_value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    assign live[i] = (CNT_W'(i) < count);

    sle_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .hit_data   (cell_hit[i]),
      .match      (cell_match[i])
    );
  end

  always_comb begin
    removed_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_or = removed_or | cell_hit[i];
    end
  end

  assign chunk = match_vec[SCAN_W-1:0];

  always_comb begin
    enc = '0;
    for (int k = SCAN_W - 1; k >= 0; k--) begin
      if (chunk[k]) begin
        enc = ENC_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ((state == ST_DONE) && out_free) || (out_valid && !out_ready);
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_action   <= action;
            req_position <= position;
            req_value    <= value;
            req_ok       <= ((action == ACT_INSERT) && ins_ok) ||
                            ((action == ACT_DELETE) && del_ok);
            state        <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_removed <= (req_ok && (req_action == ACT_DELETE)) ? removed_or : '0;
          res_found   <= '0;
          scan_base   <= '0;
          match_vec   <= MV_W'(cell_match & live);
          if (req_ok && (req_action == ACT_INSERT)) begin
            count <= count + CNT_W'(1);
          end else if (req_ok && (req_action == ACT_DELETE)) begin
            count <= count - CNT_W'(1);
          end
          state <= (req_action == ACT_LOCATE) ? ST_SCAN : ST_DONE;
        end
        ST_SCAN: begin
          if (chunk != '0) begin
            res_found <= POS_W'(scan_base + BASE_W'(enc) + BASE_W'(1));
            state     <= ST_DONE;
          end else if (match_vec == '0) begin
            state <= ST_DONE;
          end else begin
            match_vec <= match_vec >> SCAN_W;
            scan_base <= scan_base + BASE_W'(SCAN_W);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            ok             <= (req_action == ACT_LOCATE) ? (res_found != '0) : req_ok;
            removed_value  <= res_removed;
            found_position <= res_found;
            list_length    <= POS_W'(count);
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/sv/sequential_list_engine_test.sv]
// Self-checking testbench for the sequential list engine: drives insert, delete and
// locate requests, keeps its own copy of the list, and checks every result in order.
// Depends on sle_pkg and the sequential_list_engine design.
`timescale 1ns / 1ps

module sequential_list_engine_test;
  import sle_pkg::*;

  localparam int LIST_CAPACITY = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 3 + LIST_CAPACITY / 8 + 8;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] removed;
    logic [POS_W-1:0]         found;
    logic [POS_W-1:0]         length;
  } list_result_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACT_W-1:0]         action;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     ok;
  logic signed [DATA_W-1:0] removed_value;
  logic [POS_W-1:0]         found_position;
  logic [POS_W-1:0]         list_length;

  logic signed [DATA_W-1:0] list_copy [LIST_CAPACITY];
  int                       list_count;
  list_result_t             expected_results [$];
  int                       error_count;
  int                       cycle_count;
  int                       send_idle_pct;
  int                       recv_stall_pct;
  int                       hold_left;

  sequential_list_engine #(.CAPACITY(LIST_CAPACITY)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .position       (position),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .removed_value  (removed_value),
    .found_position (found_position),
    .list_length    (list_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sequential_list_engine test failed");
      $finish;
    end
  end

  // The receiver stalls at random, or holds off completely while hold_left counts down.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding, got ok %b length %0d",
                 $time, ok, list_length);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        report_field("ok", DATA_W'(want.ok), DATA_W'(ok));
        report_field("removed_value", want.removed, removed_value);
        report_field("found_position", DATA_W'(want.found), DATA_W'(found_position));
        report_field("list_length", DATA_W'(want.length), DATA_W'(list_length));
      end
    end
  end

  task automatic apply_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
    list_result_t res;
    int           j;
    res = '0;
    case (act)
      ACT_INSERT: begin
        if (pos >= 1 && pos <= list_count + 1 && list_count < LIST_CAPACITY) begin
          for (j = list_count; j >= pos; j--) list_copy[j] = list_copy[j-1];
          list_copy[pos-1] = val;
          list_count++;
          res.ok = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (pos >= 1 && pos <= list_count) begin
          res.removed = list_copy[pos-1];
          for (j = pos - 1; j < list_count - 1; j++) list_copy[j] = list_copy[j+1];
          list_count--;
          res.ok = 1'b1;
        end
      end
      ACT_LOCATE: begin
        for (j = 0; j < list_count && res.found == 0; j++) begin
          if (list_copy[j] == val) res.found = POS_W'(j + 1);
        end
        res.ok = (res.found != 0);
      end
      default: ;
    endcase
    res.length = POS_W'(list_count);
    expected_results.push_back(res);
  endtask

  task automatic send_request(input logic [ACT_W-1:0] act, input int pos,
                              input logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    position <= POS_W'(pos);
    value    <= val;
    do @(posedge clk); while (!in_ready);
    apply_request(act, POS_W'(pos), val);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5, 6: return $signed(DATA_W'($urandom_range(7)));
      default: return $signed(DATA_W'($urandom));
    endcase
  endfunction

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(ACT_LOCATE, 0, 32'sd5);
    send_request(ACT_DELETE, 1, 32'sd0);
    send_request(ACT_INSERT, 0, 32'sd1);
    send_request(ACT_INSERT, 2, 32'sd1);
    send_request(ACT_INSERT, 1, 32'sh7fff_ffff);
    send_request(ACT_INSERT, 1, 32'sh8000_0000);
    send_request(ACT_INSERT, 3, -32'sd1);
    send_request(ACT_INSERT, 2, 32'sd0);
    send_request(ACT_INSERT, 6, 32'sd9);
    send_request(ACT_INSERT, 127, 32'sd9);
    send_request(ACT_LOCATE, 127, 32'sh8000_0000);
    send_request(ACT_LOCATE, 0, -32'sd1);
    send_request(ACT_LOCATE, 0, 32'sd12345);
    send_request(ACT_INSERT, 4, 32'sd0);
    send_request(ACT_LOCATE, 0, 32'sd0);
    send_request(ACT_UNUSED, 1, 32'sd0);
    send_request(ACT_DELETE, 6, 32'sd0);
    send_request(ACT_DELETE, 0, 32'sd0);
    send_request(ACT_DELETE, 127, -32'sd1);
    send_request(ACT_DELETE, 5, 32'sd0);
    send_request(ACT_DELETE, 1, 32'sd0);
    send_request(ACT_DELETE, 2, 32'sd0);
    send_request(ACT_DELETE, 1, 32'sd0);
    send_request(ACT_DELETE, 1, 32'sd0);
    send_request(ACT_LOCATE, 0, 32'sd0);
    wait_drained();
  endtask

  task automatic test_full_list();
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    while (list_count < LIST_CAPACITY) begin
      send_request(ACT_INSERT, $urandom_range(list_count + 1, 1), $signed(DATA_W'($urandom)));
    end
    send_request(ACT_INSERT, 1, 32'sd1);
    send_request(ACT_INSERT, LIST_CAPACITY + 1, 32'sd1);
    send_request(ACT_LOCATE, 0, list_copy[LIST_CAPACITY-1]);
    send_request(ACT_LOCATE, 0, pick_value());
    send_request(ACT_DELETE, LIST_CAPACITY + 1, 32'sd0);
    send_request(ACT_DELETE, LIST_CAPACITY, 32'sd0);
    send_request(ACT_INSERT, LIST_CAPACITY, -32'sd7);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_left = 200;
    repeat (30) begin
      send_request(ACT_LOCATE, 0, list_copy[$urandom_range(list_count - 1)]);
      send_request(ACT_DELETE, $urandom_range(list_count, 1), 32'sd0);
      send_request(ACT_INSERT, $urandom_range(list_count + 1, 1), pick_value());
    end
    wait_drained();
  endtask

  task automatic run_random_phase(input int n, input int idle_pct, input int stall_pct);
    bit   growing;
    int   roll;
    int   pos;
    logic [ACT_W-1:0] act;
    logic signed [DATA_W-1:0] val;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    growing = (list_count < LIST_CAPACITY / 2);
    repeat (n) begin
      roll = $urandom_range(99);
      val  = pick_value();
      pos  = $urandom_range(127);
      if (roll < 5) begin
        act = ACT_UNUSED;
      end else if (roll < 25) begin
        act = ACT_LOCATE;
        if (list_count > 0 && $urandom_range(9) < 7) begin
          val = list_copy[$urandom_range(list_count - 1)];
        end
      end else if (roll < (growing ? 85 : 40)) begin
        act = ACT_INSERT;
        if ($urandom_range(99) < 85) pos = $urandom_range(list_count + 1, 1);
        else pos = $urandom_range(1) ? 0 : $urandom_range(127, list_count + 2);
      end else begin
        act = ACT_DELETE;
        if (list_count > 0 && $urandom_range(99) < 85) pos = $urandom_range(list_count, 1);
        else pos = $urandom_range(1) ? 0 : $urandom_range(127, list_count + 1);
      end
      send_request(act, pos, val);
      if (list_count == LIST_CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
      if (list_count == 0 && $urandom_range(3) == 0) growing = 1'b1;
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_random_phase(365, 0, 0);
    run_random_phase(365, 75, 0);
    run_random_phase(365, 0, 75);
    run_random_phase(365, 18, 18);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_INSERT;
    position       = '0;
    value          = '0;
    list_count     = 0;
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_list();
    test_backpressure();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("sequential_list_engine test passed");
    end else begin
      $display("sequential_list_engine test failed");
    end
    $finish;
  end

endmodule
